/* rtl/core/trfd_pkg.sv */
// Package for the touch report frame decoder.
// Holds field widths, status and register codes, and the stored point type.
// No dependencies.
package trfd_pkg;

   localparam int MAX_FINGERS = 5;
   localparam int SLOT_W      = 3;
   localparam int POS_W       = 16;
   localparam int BYTE_W      = 8;
   localparam int BPOS_W      = 5;
   localparam int CSR_IDX_W   = 3;

   localparam logic [1:0] ST_SLOT      = 2'd0;
   localparam logic [1:0] ST_NOT_READY = 2'd1;
   localparam logic [1:0] ST_RELOAD    = 2'd2;
   localparam logic [1:0] ST_CKSUM     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_Y = 3'd4;

   localparam logic [BYTE_W-1:0] READY_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] READY_VAL  = 8'h80;
   localparam logic [3:0]        KEY_MASK   = 4'hF;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [BYTE_W-1:0] w;
   } point_type;

endpackage

/* rtl/core/touch_report_frame_decoder_top.sv */
// Touch report frame decoder with one shared saturating subtract unit; depends on trfd_pkg.
// Frame bytes may follow back to back while the decoder is idle; none is taken while results are pending.
// After the checksum byte a status result is valid the next cycle, or the slot reports
// follow: slots are scanned, touched ones first, each touched report passes the flip X and
// flip Y steps, a released report goes straight out, and output stalls hold the flow.
// Synchronous reset: control registers to defaults; result data, point store not cleared.
module touch_report_frame_decoder_top
   import trfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_frame_byte,
   input  logic                  req_frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic                  rsp_touching,
   output logic [POS_W-1:0]      rsp_pos_x,
   output logic [POS_W-1:0]      rsp_pos_y,
   output logic [BYTE_W-1:0]     rsp_contact_width,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [POS_W-1:0]      csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_FX   = 3'd2;
   localparam logic [2:0] S_FY   = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [POS_W-1:0]       max_x_ff, max_y_ff;
   logic                   swap_ff, flip_x_ff, flip_y_ff;
   logic [BPOS_W-1:0]      bpos_ff, bpos_in;
   logic [BPOS_W-1:0]      data_end_ff, data_end_in;
   logic [MAX_FINGERS-1:0] mask_ff, mask_in;
   logic                   ready_ok_ff, ready_ok_in;
   logic                   reload_ff, reload_in;
   logic [BYTE_W-1:0]      sum_ff, sum_in;
   logic                   active_ff, active_in;
   logic [2:0]             part_ff, part_in;
   logic [SLOT_W-1:0]      entry_ff, entry_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   pass_ff, pass_in;
   logic [SLOT_W-1:0]      k_ff, k_in;
   logic [SLOT_W-1:0]      ord_ff, ord_in;

   logic [1:0]             status_ff, status_in;
   logic                   touch_ff, touch_in;
   logic [POS_W-1:0]       cx_ff, cx_in, cy_ff, cy_in;
   logic [BYTE_W-1:0]      w_ff, w_in;
   logic                   last_ff, last_in;

   point_type              store_ff [MAX_FINGERS];
   logic                   store_we;

   logic                   req_fire, rsp_fire, csr_fire;
   logic [2:0]             pop;
   logic                   slot_bit, slot_match, slot_end;
   point_type              rd_pt;
   logic [POS_W-1:0]       sub_lim, sub_val, sub_res;
   logic [POS_W:0]         sub_diff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign csr_fire  = csr_valid && csr_ready;

   assign rsp_status        = status_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_touching      = touch_ff;
   assign rsp_pos_x         = cx_ff;
   assign rsp_pos_y         = cy_ff;
   assign rsp_contact_width = w_ff;
   assign rsp_last          = last_ff;

   // shared saturating subtract unit
   assign sub_lim  = (state_ff == S_FX) ? max_x_ff : max_y_ff;
   assign sub_val  = (state_ff == S_FX) ? cx_ff : cy_ff;
   assign sub_diff = {1'b0, sub_lim} - {1'b0, sub_val};
   assign sub_res  = sub_diff[POS_W] ? '0 : sub_diff[POS_W-1:0];

   assign slot_bit   = mask_ff[slot_ff];
   assign slot_match = pass_ff ? !slot_bit : slot_bit;
   assign slot_end   = (slot_ff == SLOT_W'(MAX_FINGERS - 1));
   assign rd_pt      = store_ff[ord_ff];

   always_comb begin
      pop = '0;
      for (int i = 0; i < MAX_FINGERS; i++) begin
         pop = pop + 3'(req_frame_byte[i]);
      end
   end

   always_comb begin
      state_in    = state_ff;
      bpos_in     = bpos_ff;
      data_end_in = data_end_ff;
      mask_in     = mask_ff;
      ready_ok_in = ready_ok_ff;
      reload_in   = reload_ff;
      sum_in      = sum_ff;
      active_in   = active_ff;
      part_in     = part_ff;
      entry_in    = entry_ff;
      slot_in     = slot_ff;
      pass_in     = pass_ff;
      k_in        = k_ff;
      ord_in      = ord_ff;
      status_in   = status_ff;
      touch_in    = touch_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      w_in        = w_ff;
      last_in     = last_ff;
      store_we    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_frame_start) begin
                  mask_in     = req_frame_byte[MAX_FINGERS-1:0];
                  ready_ok_in = (req_frame_byte & READY_MASK) == READY_VAL;
                  data_end_in = BPOS_W'({pop, 2'b00}) + BPOS_W'(pop) + BPOS_W'(2);
                  reload_in   = 1'b0;
                  sum_in      = '0;
                  bpos_in     = BPOS_W'(1);
                  active_in   = 1'b1;
                  part_in     = '0;
                  entry_in    = '0;
               end else if (active_ff) begin
                  if (bpos_ff == BPOS_W'(1)) begin
                     reload_in = (req_frame_byte[3:0] & KEY_MASK) == KEY_MASK;
                     bpos_in   = BPOS_W'(2);
                  end else if (bpos_ff < data_end_ff) begin
                     store_we = 1'b1;
                     sum_in   = sum_ff + req_frame_byte;
                     bpos_in  = bpos_ff + BPOS_W'(1);
                     if (part_ff == 3'd4) begin
                        part_in  = '0;
                        entry_in = entry_ff + SLOT_W'(1);
                     end else begin
                        part_in = part_ff + 3'd1;
                     end
                  end else begin
                     active_in = 1'b0;
                     bpos_in   = '0;
                     slot_in   = '0;
                     pass_in   = 1'b0;
                     k_in      = '0;
                     ord_in    = '0;
                     touch_in  = 1'b0;
                     cx_in     = '0;
                     cy_in     = '0;
                     w_in      = '0;
                     last_in   = 1'b1;
                     if (!ready_ok_ff) begin
                        status_in = ST_NOT_READY;
                        state_in  = S_OUT;
                     end else if (reload_ff) begin
                        status_in = ST_RELOAD;
                        state_in  = S_OUT;
                     end else if (sum_ff != req_frame_byte) begin
                        status_in = ST_CKSUM;
                        state_in  = S_OUT;
                     end else begin
                        status_in = ST_SLOT;
                        last_in   = 1'b0;
                        state_in  = S_SCAN;
                     end
                  end
               end
            end
         end
         S_SCAN: begin
            if (slot_match) begin
               if (!pass_ff) begin
                  touch_in = 1'b1;
                  cx_in    = swap_ff ? rd_pt.y : rd_pt.x;
                  cy_in    = swap_ff ? rd_pt.x : rd_pt.y;
                  w_in     = rd_pt.w;
                  ord_in   = ord_ff + SLOT_W'(1);
                  state_in = S_FX;
               end else begin
                  touch_in = 1'b0;
                  cx_in    = '0;
                  cy_in    = '0;
                  w_in     = '0;
                  last_in  = (k_ff == SLOT_W'(MAX_FINGERS - 1));
                  state_in = S_OUT;
               end
            end else if (slot_end) begin
               pass_in = 1'b1;
               slot_in = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         S_FX: begin
            if (flip_x_ff) begin
               cx_in = sub_res;
            end
            state_in = S_FY;
         end
         S_FY: begin
            if (flip_y_ff) begin
               cy_in = sub_res;
            end
            last_in  = (k_ff == SLOT_W'(MAX_FINGERS - 1));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_fire) begin
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + SLOT_W'(1);
                  state_in = S_SCAN;
                  if (slot_end) begin
                     pass_in = 1'b1;
                     slot_in = '0;
                  end else begin
                     slot_in = slot_ff + SLOT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         max_x_ff    <= POS_W'(800);
         max_y_ff    <= POS_W'(480);
         swap_ff     <= 1'b0;
         flip_x_ff   <= 1'b0;
         flip_y_ff   <= 1'b0;
         bpos_ff     <= '0;
         data_end_ff <= '0;
         mask_ff     <= '0;
         ready_ok_ff <= 1'b0;
         reload_ff   <= 1'b0;
         sum_ff      <= '0;
         active_ff   <= 1'b0;
         part_ff     <= '0;
         entry_ff    <= '0;
         slot_ff     <= '0;
         pass_ff     <= 1'b0;
         k_ff        <= '0;
         ord_ff      <= '0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bpos_ff     <= bpos_in;
         data_end_ff <= data_end_in;
         mask_ff     <= mask_in;
         ready_ok_ff <= ready_ok_in;
         reload_ff   <= reload_in;
         sum_ff      <= sum_in;
         active_ff   <= active_in;
         part_ff     <= part_in;
         entry_ff    <= entry_in;
         slot_ff     <= slot_in;
         pass_ff     <= pass_in;
         k_ff        <= k_in;
         ord_ff      <= ord_in;
         last_ff     <= last_in;
         if (csr_fire) begin
            case (csr_index)
               CSR_MAX_X:  max_x_ff  <= csr_data;
               CSR_MAX_Y:  max_y_ff  <= csr_data;
               CSR_SWAP:   swap_ff   <= csr_data[0];
               CSR_FLIP_X: flip_x_ff <= csr_data[0];
               CSR_FLIP_Y: flip_y_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      touch_ff  <= touch_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      w_ff      <= w_in;
      if (store_we) begin
         case (part_ff)
            3'd0:    store_ff[entry_ff].x[15:8] <= req_frame_byte;
            3'd1:    store_ff[entry_ff].x[7:0]  <= req_frame_byte;
            3'd2:    store_ff[entry_ff].y[15:8] <= req_frame_byte;
            3'd3:    store_ff[entry_ff].y[7:0]  <= req_frame_byte;
            default: store_ff[entry_ff].w       <= req_frame_byte;
         endcase
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result is pending");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_SLOT) |-> rsp_last)
      else $error("status result not marked last");

   a_release_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SLOT && !rsp_touching) |->
      (rsp_pos_x == '0 && rsp_pos_y == '0 && rsp_contact_width == '0))
      else $error("released slot carries coordinates");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("no return to byte collection after final result");

endmodule
